/* sv/mp2a_pkg.sv */
// Package for the 2D max pooling block with argmax.
// Sizes, config register indexes, the queued operation type and the
// divide-by-pool-size helper. No dependencies.
package mp2a_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_COLS);
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int POOL_W     = 4;
  localparam int WIN_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam int COL_LIMIT  = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam int ROW_LIMIT  = 1024;
  localparam int POOL_MAX   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS  = 2'd2;

  localparam int RECIP_SHIFT = 13;

  // Running maximum and its position for one pooling column.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
  } entry_t;

  // One classified sample on its way to the update stage.
  typedef struct packed {
    logic [IDX_W-1:0]             idx;
    logic                         first;
    logic                         emit;
    logic                         last;
    logic signed [VALUE_BITS-1:0] value;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic [COORD_W-1:0]           prow;
    logic [COORD_W-1:0]           pcol;
  } op_t;

  // n / p for p in 1..8 and n <= 1024: multiply by a 13-bit-scaled
  // reciprocal, exact over that range.
  function automatic logic [DIM_W-1:0] div_by_pool(input logic [DIM_W-1:0] n,
                                                   input logic [POOL_W-1:0] p);
    logic [13:0] recip;
    logic [24:0] prod;
    case (p)
      4'd1:    recip = 14'd8192;
      4'd2:    recip = 14'd4096;
      4'd3:    recip = 14'd2731;
      4'd4:    recip = 14'd2048;
      4'd5:    recip = 14'd1639;
      4'd6:    recip = 14'd1366;
      4'd7:    recip = 14'd1171;
      4'd8:    recip = 14'd1024;
      default: recip = 14'd8192;
    endcase
    prod = 25'(n) * 25'(recip);
    return prod[RECIP_SHIFT+DIM_W-1:RECIP_SHIFT];
  endfunction

endpackage

/* sv/mp2a_if.sv */
// Stream interfaces for the max pooling block: sample input and pooled result.
// Depends on mp2a_pkg.
interface mp2a_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mp2a_pkg::VALUE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface mp2a_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mp2a_pkg::VALUE_BITS-1:0] pooled_value;
  logic [mp2a_pkg::COORD_W-1:0]          max_row;
  logic [mp2a_pkg::COORD_W-1:0]          max_col;
  logic [mp2a_pkg::COORD_W-1:0]          pooled_row;
  logic [mp2a_pkg::COORD_W-1:0]          pooled_col;
  logic                                  last_of_plane;

  modport source (output valid, output pooled_value, output max_row, output max_col,
                  output pooled_row, output pooled_col, output last_of_plane,
                  input ready);
  modport sink   (input valid, input pooled_value, input max_row, input max_col,
                  input pooled_row, input pooled_col, input last_of_plane,
                  output ready);
endinterface

/* sv/max_pool_2d_argmax_top.sv */
// Channel   Dir  Transfer when         Payload
// in_ch     in   valid && ready        sample_value (Q8.8, raster order)
// out_ch    out  valid && ready        pooled_value, max_row/col, pooled_row/col, last
// cfg       in   cfg_we_i              cfg_idx_i selects pool_size/map_cols/map_rows
//
// One sample per cycle unless the queue is full; a result goes via queue and update stage to res_q.
// Rate is set by the partial store: one read and one write per cycle, with a
// bypass for back-to-back samples of the same pooling column.
// Reset clears counters and control; the partial store needs no clearing pass.
// A stall on out_ch fills the 4-entry queue before in_ch.ready drops.
//
// Top level of the 2D max pooling block; depends on mp2a_pkg, mp2a_if and submodules.
module max_pool_2d_argmax_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mp2a_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mp2a_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mp2a_in_if.sink                         in_ch,
  mp2a_out_if.source                      out_ch
);

  logic          push, q_full, q_valid, pop;
  mp2a_pkg::op_t push_op, head_op;

  mp2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  mp2a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  mp2a_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (head_op),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule

/* sv/mp2a_front.sv */
// Front end: config registers, raster and window counters, sample classification.
// Depends on mp2a_pkg and mp2a_in_if.
module mp2a_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mp2a_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mp2a_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mp2a_in_if.sink                         in_ch,
  input  logic                            q_full_i,
  output logic                            push_o,
  output mp2a_pkg::op_t                   op_o
);

  logic [mp2a_pkg::POOL_W-1:0]  pool_q;
  logic [mp2a_pkg::DIM_W-1:0]   cols_q, rows_q;
  logic [mp2a_pkg::COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [mp2a_pkg::WIN_W-1:0]   ciw_q, ciw_d, riw_q, riw_d;

  logic [mp2a_pkg::POOL_W-1:0]  p;
  logic [mp2a_pkg::WIN_W-1:0]   p_m1;
  logic [mp2a_pkg::DIM_W-1:0]   cols, rows, pooled_cols, pooled_rows, pc, pr;
  logic                         accept, in_region, col_wrap, row_wrap;

  always_comb begin
    if (pool_q == '0)                                   p = 4'd1;
    else if (pool_q > mp2a_pkg::POOL_W'(mp2a_pkg::POOL_MAX)) p = 4'd8;
    else                                                p = pool_q;

    if (cols_q == '0)                                         cols = 11'd1;
    else if (cols_q > mp2a_pkg::DIM_W'(mp2a_pkg::COL_LIMIT)) cols = mp2a_pkg::DIM_W'(mp2a_pkg::COL_LIMIT);
    else                                                      cols = cols_q;

    if (rows_q == '0)                                         rows = 11'd1;
    else if (rows_q > mp2a_pkg::DIM_W'(mp2a_pkg::ROW_LIMIT)) rows = mp2a_pkg::DIM_W'(mp2a_pkg::ROW_LIMIT);
    else                                                      rows = rows_q;
  end

  assign p_m1        = mp2a_pkg::WIN_W'(p - 4'd1);
  assign pooled_cols = mp2a_pkg::div_by_pool(cols, p);
  assign pooled_rows = mp2a_pkg::div_by_pool(rows, p);
  assign pc          = mp2a_pkg::div_by_pool({1'b0, col_q}, p);
  assign pr          = mp2a_pkg::div_by_pool({1'b0, row_q}, p);
  // c < pooled_cols*p is the same as c/p < pooled_cols
  assign in_region   = (pc < pooled_cols) && (pr < pooled_rows);

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_o      = accept && in_region;

  always_comb begin
    op_o.idx   = pc[mp2a_pkg::IDX_W-1:0];
    op_o.first = (riw_q == '0) && (ciw_q == '0);
    op_o.emit  = (riw_q >= p_m1) && (ciw_q >= p_m1);
    op_o.last  = (pr + 11'd1 == pooled_rows) && (pc + 11'd1 == pooled_cols);
    op_o.value = in_ch.sample_value;
    op_o.row   = row_q;
    op_o.col   = col_q;
    op_o.prow  = pr[mp2a_pkg::COORD_W-1:0];
    op_o.pcol  = pc[mp2a_pkg::COORD_W-1:0];
  end

  assign col_wrap = ({1'b0, col_q} + 11'd1) >= cols;
  assign row_wrap = ({1'b0, row_q} + 11'd1) >= rows;

  always_comb begin
    col_d = col_q;
    ciw_d = ciw_q;
    row_d = row_q;
    riw_d = riw_q;
    if (col_wrap) begin
      col_d = '0;
      ciw_d = '0;
      if (row_wrap) begin
        row_d = '0;
        riw_d = '0;
      end else begin
        row_d = row_q + 10'd1;
        riw_d = (riw_q >= p_m1) ? '0 : riw_q + 3'd1;
      end
    end else begin
      col_d = col_q + 10'd1;
      ciw_d = (ciw_q >= p_m1) ? '0 : ciw_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= 4'd2;
      cols_q <= 11'd1024;
      rows_q <= 11'd1024;
      col_q  <= '0;
      row_q  <= '0;
      ciw_q  <= '0;
      riw_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mp2a_pkg::CFG_POOL_SIZE: pool_q <= cfg_data_i[mp2a_pkg::POOL_W-1:0];
          mp2a_pkg::CFG_MAP_COLS:  cols_q <= cfg_data_i;
          mp2a_pkg::CFG_MAP_ROWS:  rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        ciw_q <= ciw_d;
        riw_q <= riw_d;
      end
    end
  end

endmodule

/* sv/mp2a_queue.sv */
// Short queue of classified operations between front and back end.
// Depends on mp2a_pkg.
module mp2a_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mp2a_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mp2a_pkg::op_t op_o
);

  mp2a_pkg::op_t                 slot_q [mp2a_pkg::QUEUE_DEPTH];
  logic [mp2a_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [mp2a_pkg::QPTR_W:0]     count_q, count_d;

  assign full_o  = count_q == (mp2a_pkg::QPTR_W+1)'(mp2a_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign op_o    = slot_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule

/* sv/mp2a_back.sv */
// Back end: per-column partial store, read-modify-write with bypass, result register.
// Depends on mp2a_pkg and mp2a_out_if.
module mp2a_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mp2a_pkg::op_t q_op_i,
  output logic          pop_o,
  mp2a_out_if.source    out_ch
);

  mp2a_pkg::entry_t store_q [mp2a_pkg::MAX_COLS];

  logic             b_valid_q, byp_valid_q, out_valid_q;
  mp2a_pkg::op_t    b_op_q;
  mp2a_pkg::entry_t rdata_q, byp_q, old_entry, new_entry, res_q;
  logic [mp2a_pkg::COORD_W-1:0] prow_q, pcol_q;
  logic             last_q, out_free, b_adv, b_load, take;

  assign out_free = !out_valid_q || out_ch.ready;
  assign b_adv    = b_valid_q && (!b_op_q.emit || out_free);
  assign b_load   = !b_valid_q || b_adv;
  assign pop_o    = q_valid_i && b_load;

  // the op leaving the update stage writes on the same edge the next one reads
  assign old_entry = byp_valid_q ? byp_q : rdata_q;
  assign take      = b_op_q.first || (b_op_q.value > old_entry.value);

  always_comb begin
    if (take) begin
      new_entry.value = b_op_q.value;
      new_entry.row   = b_op_q.row;
      new_entry.col   = b_op_q.col;
    end else begin
      new_entry = old_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv)  store_q[b_op_q.idx] <= new_entry;
    if (pop_o)  rdata_q <= store_q[q_op_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_op_q <= q_op_i;
      byp_q  <= new_entry;
    end
    if (b_adv && b_op_q.emit) begin
      res_q  <= new_entry;
      prow_q <= b_op_q.prow;
      pcol_q <= b_op_q.pcol;
      last_q <= b_op_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q   <= 1'b1;
        byp_valid_q <= b_adv && (b_op_q.idx == q_op_i.idx);
      end else if (b_adv) begin
        b_valid_q   <= 1'b0;
      end
      if (b_adv && b_op_q.emit) out_valid_q <= 1'b1;
      else if (out_ch.ready)    out_valid_q <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.pooled_value  = res_q.value;
  assign out_ch.max_row       = res_q.row;
  assign out_ch.max_col       = res_q.col;
  assign out_ch.pooled_row    = prow_q;
  assign out_ch.pooled_col    = pcol_q;
  assign out_ch.last_of_plane = last_q;

endmodule

/* test/max_pool_2d_argmax_top_tb.sv */
// Self-checking testbench for max_pool_2d_argmax_top: streams feature map planes through
// the block under random gaps and stalls and checks every pooled result against a
// local window-maximum predictor. Depends on mp2a_pkg, mp2a_if and the block itself.
module max_pool_2d_argmax_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mp2a_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 200;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic signed [mp2a_pkg::VALUE_BITS-1:0] value;
    logic [mp2a_pkg::COORD_W-1:0]           max_row;
    logic [mp2a_pkg::COORD_W-1:0]           max_col;
    logic [mp2a_pkg::COORD_W-1:0]           pooled_row;
    logic [mp2a_pkg::COORD_W-1:0]           pooled_col;
    logic                                   last;
  } pooled_t;

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            cfg_we_i   = 1'b0;
  logic [mp2a_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [mp2a_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  mp2a_in_if  in_if ();
  mp2a_out_if out_if ();

  max_pool_2d_argmax_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: register copies, per-column running maxima, raster position.
  logic [mp2a_pkg::POOL_W-1:0]            pool_reg;
  logic [mp2a_pkg::DIM_W-1:0]             cols_reg;
  logic [mp2a_pkg::DIM_W-1:0]             rows_reg;
  logic signed [mp2a_pkg::VALUE_BITS-1:0] run_max [mp2a_pkg::MAX_COLS];
  logic [mp2a_pkg::COORD_W-1:0]           run_row [mp2a_pkg::MAX_COLS];
  logic [mp2a_pkg::COORD_W-1:0]           run_col [mp2a_pkg::MAX_COLS];
  int unsigned                            col_pos, row_pos, col_in_win, row_in_win;
  pooled_t                                predicted_maxima [$];

  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned configs_used = 0;
  int unsigned stall_left   = 0;
  bit          steady_flow  = 1'b0;
  pooled_t     observed;
  pooled_t     wanted;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic string fmt_pool(input pooled_t p);
    return $sformatf("value %0d max (%0d,%0d) pooled (%0d,%0d) last %0b",
                     p.value, p.max_row, p.max_col, p.pooled_row, p.pooled_col, p.last);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [mp2a_pkg::VALUE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return mp2a_pkg::VALUE_BITS'($urandom_range(0, 3)) - 16'sd2;  // tie-prone
      default: return mp2a_pkg::VALUE_BITS'($urandom);
    endcase
  endfunction

  // Window max with argmax for one accepted sample, then raster advance.
  task automatic pool_sample(input logic signed [mp2a_pkg::VALUE_BITS-1:0] v);
    int unsigned p, cols, rows, pcols, prows, pc, pr;
    pooled_t res;
    p     = clamp_dim(pool_reg, mp2a_pkg::POOL_MAX);
    cols  = clamp_dim(cols_reg, mp2a_pkg::COL_LIMIT);
    rows  = clamp_dim(rows_reg, mp2a_pkg::ROW_LIMIT);
    pcols = cols / p;
    prows = rows / p;
    if (col_pos < pcols * p && row_pos < prows * p) begin
      pc = col_pos / p;
      pr = row_pos / p;
      // strict compare: ties keep the earliest sample
      if ((row_in_win == 0 && col_in_win == 0) || v > run_max[pc]) begin
        run_max[pc] = v;
        run_row[pc] = mp2a_pkg::COORD_W'(row_pos);
        run_col[pc] = mp2a_pkg::COORD_W'(col_pos);
      end
      if (row_in_win >= p - 1 && col_in_win >= p - 1) begin
        res.value      = run_max[pc];
        res.max_row    = run_row[pc];
        res.max_col    = run_col[pc];
        res.pooled_row = mp2a_pkg::COORD_W'(pr);
        res.pooled_col = mp2a_pkg::COORD_W'(pc);
        res.last       = (pr + 1 == prows) && (pc + 1 == pcols);
        predicted_maxima.push_back(res);
      end
    end
    if (col_pos + 1 >= cols) begin
      col_pos    = 0;
      col_in_win = 0;
      if (row_pos + 1 >= rows) begin
        row_pos    = 0;
        row_in_win = 0;
      end else begin
        row_pos    = row_pos + 1;
        row_in_win = (row_in_win >= p - 1) ? 0 : row_in_win + 1;
      end
    end else begin
      col_pos    = col_pos + 1;
      col_in_win = (col_in_win >= p - 1) ? 0 : col_in_win + 1;
    end
  endtask

  task automatic send_sample(input logic signed [mp2a_pkg::VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    pool_sample(v);
    samples_sent++;
  endtask

  // Stop sending, let every predicted result arrive, then let the pipeline settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (predicted_maxima.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Caller lowers cfg_we_i once its last write is done.
  task automatic reg_write(input logic [mp2a_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mp2a_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      mp2a_pkg::CFG_POOL_SIZE: pool_reg = data[mp2a_pkg::POOL_W-1:0];
      mp2a_pkg::CFG_MAP_COLS:  cols_reg = data;
      mp2a_pkg::CFG_MAP_ROWS:  rows_reg = data;
      default:                 ;
    endcase
  endtask

  task automatic set_config(input int unsigned pool, input int unsigned cols,
                            input int unsigned rows);
    drain();
    reg_write(mp2a_pkg::CFG_POOL_SIZE, mp2a_pkg::CFG_DATA_W'(pool));
    reg_write(mp2a_pkg::CFG_MAP_COLS, mp2a_pkg::CFG_DATA_W'(cols));
    reg_write(mp2a_pkg::CFG_MAP_ROWS, mp2a_pkg::CFG_DATA_W'(rows));
    if ($urandom_range(0, 3) == 0) reg_write(CFG_SPARE, mp2a_pkg::CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    configs_used++;
  endtask

  task automatic send_plane();
    int unsigned n;
    n = clamp_dim(cols_reg, mp2a_pkg::COL_LIMIT) * clamp_dim(rows_reg, mp2a_pkg::ROW_LIMIT);
    repeat (n) send_sample(rand_sample());
  endtask

  task automatic finish_plane();
    while (col_pos != 0 || row_pos != 0) send_sample(rand_sample());
  endtask

  // Value extremes, ties, and a maximum on the first and on the last window sample.
  task automatic test_directed_windows();
    logic signed [mp2a_pkg::VALUE_BITS-1:0] pattern [16];
    pattern = '{16'sd5,  16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh7fff, -16'sd3, 16'sh8000, 16'sh8000,
                -16'sd1, -16'sd2, 16'sd0, 16'sd0,
                16'sd7,  16'sd8,  16'sd0, 16'sd1};
    set_config(2, 4, 2);
    foreach (pattern[i]) send_sample(pattern[i]);
  endtask

  task automatic test_edge_leftovers();
    set_config(3, 7, 5);
    send_plane();
    set_config(4, 10, 6);
    send_plane();
  endtask

  task automatic test_pool_limits();
    set_config(0, 3, 2);    // pool size zero acts as one
    send_plane();
    set_config(15, 16, 8);  // saturates to eight
    send_plane();
    set_config(1, 1, 1);
    repeat (3) send_plane();
  endtask

  task automatic test_map_below_window();
    set_config(8, 5, 9);
    send_plane();
    set_config(6, 7, 5);
    send_plane();
  endtask

  // Width saturates to the full 1024 columns; this also writes every entry of the
  // partial store.
  task automatic test_full_width();
    steady_flow = 1'b1;
    set_config(1, 2047, 0);
    send_plane();
    steady_flow = 1'b0;
  endtask

  task automatic test_mid_plane_writes();
    set_config(3, 12, 9);
    repeat (8) begin
      repeat ($urandom_range(1, 40)) send_sample(rand_sample());
      drain();
      case ($urandom_range(0, 3))
        0: reg_write(mp2a_pkg::CFG_POOL_SIZE, mp2a_pkg::CFG_DATA_W'($urandom_range(0, 15)));
        1: reg_write(mp2a_pkg::CFG_MAP_COLS, mp2a_pkg::CFG_DATA_W'($urandom_range(0, 16)));
        2: reg_write(mp2a_pkg::CFG_MAP_ROWS, mp2a_pkg::CFG_DATA_W'($urandom_range(0, 16)));
        default: reg_write(CFG_SPARE, mp2a_pkg::CFG_DATA_W'($urandom));
      endcase
      cfg_we_i <= 1'b0;
      configs_used++;
    end
    finish_plane();
  endtask

  task automatic test_random_planes();
    int unsigned start, pool, cols, rows, r;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 15);
      if (r == 0) pool = 0;
      else if (r == 1) pool = $urandom_range(9, 15);
      else if (r < 9) pool = $urandom_range(1, 4);
      else pool = $urandom_range(1, 8);
      cols = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
      rows = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
      set_config(pool, cols, rows);
      repeat ($urandom_range(1, 3)) send_plane();
    end
    steady_flow = 1'b0;
  endtask

  // Result side back-pressure.
  always @(posedge clk_i) begin
    if (steady_flow) begin
      out_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      observed = {out_if.pooled_value, out_if.max_row, out_if.max_col,
                  out_if.pooled_row, out_if.pooled_col, out_if.last_of_plane};
      results_seen++;
      if (predicted_maxima.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] unexpected result: %s", $realtime, fmt_pool(observed));
      end else begin
        wanted = predicted_maxima.pop_front();
        if (observed !== wanted) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] mismatch: expected %s, got %s", $realtime,
                     fmt_pool(wanted), fmt_pool(observed));
        end
      end
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.sample_value = '0;
    out_if.ready       = 1'b0;
    pool_reg   = 4'd2;
    cols_reg   = 11'd1024;
    rows_reg   = 11'd1024;
    col_pos    = 0;
    row_pos    = 0;
    col_in_win = 0;
    row_in_win = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_windows();
    test_edge_leftovers();
    test_pool_limits();
    test_map_below_window();
    test_full_width();
    test_mid_plane_writes();
    test_random_planes();
    drain();

    $display("Sent %0d samples under %0d register settings, checked %0d pooled results",
             samples_sent, configs_used, results_seen);
    $display("Covered pool sizes 0..15, map widths 0..2047, small map heights and mid-plane writes");
    if (errors == 0 && predicted_maxima.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, predicted_maxima.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", predicted_maxima.size());
    $display("Verification failed");
    $finish;
  end

endmodule
